### rtl/core/lzwd_pkg.sv
package lzwd_pkg;

    // front-end token phase
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_REF_LO,
        PH_REF_HI
    } t_phase;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LIT,
        CMD_REF
    } t_cmd_kind;

    // lo: literal byte or reference low byte; hi: reference high byte
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  lo;
        logic [7:0]  hi;
    } t_cmd;

    // queue head as seen by the back end
    typedef struct packed {
        logic  empty;
        t_cmd  head;
    } t_q_status;

    localparam int unsigned   MIN_COPY     = 3;
    localparam int unsigned   START_BACK   = 18;   // decode starts this far before wrap
    localparam int unsigned   LIMIT_W      = 24;
    localparam logic [7:0]    FLAG_FILL    = 8'hFF;
    localparam logic          REG_LIMIT    = 1'b0; // word index of output_limit
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFFFFFF;

endpackage

### rtl/core/lzss_window_decompressor_top.sv
// Path: a literal byte passes the command queue, read stage and output register;
//   a reference, after its second byte, the queue, window read and output register.
// Throughput: one compressed byte per cycle in unless the queue is full, one decompressed
//   byte per cycle out unless stalled; a reference keeps the window read port to its end.
// Reset: synchronous, active low; the window is not swept, a fill count marks
//   entries not yet written in this stream, which read back as zero.
module lzss_window_decompressor_top #(
    parameter int unsigned WIN_BYTES      = 4096, // ring window depth in bytes
    parameter int unsigned CMD_FIFO_DEPTH = 4     // commands between front and back
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // compressed byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tuser,   // [0] stream_start

    // decompressed byte stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,   // run_last: last byte of one input transfer, or the byte reaching output_limit

    // register port: output_limit at byte address 0
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lzwd_pkg::LIMIT_W-1:0] r_limit;
    logic                         cfg_wr;

    logic                s_accept;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    lzwd_pkg::t_cmd      q_cmd;
    lzwd_pkg::t_q_status q_status;

    // ---------------------------------------------------------------
    // Register port. Only one word; the low address bits select a byte
    // lane and are not decoded.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lzwd_pkg::REG_LIMIT);
    assign prdata = (paddr[2] == lzwd_pkg::REG_LIMIT) ? {8'h00, r_limit} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lzwd_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            r_limit <= pwdata[lzwd_pkg::LIMIT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Front end: token parser. Takes one byte per transfer and turns
    // literals, finished references and stream starts into commands.
    // Reference low bytes and flag bytes outside a stream start only update its own state.
    // ---------------------------------------------------------------
    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    lzwd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata),
        .i_start  (i_s_tuser),
        .o_push   (q_push),
        .o_cmd    (q_cmd)
    );

    // Short command queue; lets the parser run ahead during long copies.
    lzwd_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (q_cmd),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_full   (q_full)
    );

    // ---------------------------------------------------------------
    // Back end: copy engine. One window read issued per cycle while the read stage
    // can advance; data retired from it into the window and the output register.
    // Same-address read after write is forwarded. The emit count against
    // output_limit is kept here; suppressed bytes still go to the window.
    // ---------------------------------------------------------------
    lzwd_back #(
        .WIN_BYTES (WIN_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_status),
        .o_pop      (q_pop),
        .i_limit    (r_limit),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

### rtl/core/lzwd_ram.sv
module lzwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lzwd_front.sv
module lzwd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_start,
    output logic           o_push,
    output lzwd_pkg::t_cmd o_cmd
);

    lzwd_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_flag, n_flag;
    logic [7:0]       r_ref_lo, n_ref_lo;

    function automatic lzwd_pkg::t_phase f_next(input logic [15:0] s);
        if (!s[8]) begin
            return lzwd_pkg::PH_FLAG;
        end
        return s[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_REF_LO;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lzwd_pkg::PH_FLAG;
            r_flag   <= '0;
            r_ref_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_flag   <= n_flag;
            r_ref_lo <= n_ref_lo;
        end
    end

    always_comb begin
        lzwd_pkg::t_phase v_phase;
        logic [15:0]      v_flag;
        logic [15:0]      v_shift;

        // a stream start resets the token state before this byte is decoded
        v_phase  = i_start ? lzwd_pkg::PH_FLAG : r_phase;
        v_flag   = i_start ? 16'h0000 : r_flag;
        v_shift  = v_flag >> 1;

        n_phase  = r_phase;
        n_flag   = r_flag;
        n_ref_lo = r_ref_lo;
        o_push   = 1'b0;
        o_cmd.kind = lzwd_pkg::CMD_LIT;
        o_cmd.lo   = i_byte;
        o_cmd.hi   = 8'h00;

        if (i_accept) begin
            unique case (v_phase)
                lzwd_pkg::PH_FLAG: begin
                    n_flag     = {lzwd_pkg::FLAG_FILL, i_byte};
                    n_phase    = i_byte[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_REF_LO;
                    o_push     = i_start;
                    o_cmd.kind = lzwd_pkg::CMD_CLEAR;
                end
                lzwd_pkg::PH_LIT: begin
                    o_push     = 1'b1;
                    o_cmd.kind = lzwd_pkg::CMD_LIT;
                    n_flag     = v_shift;
                    n_phase    = f_next(v_shift);
                end
                lzwd_pkg::PH_REF_LO: begin
                    n_ref_lo   = i_byte;
                    n_phase    = lzwd_pkg::PH_REF_HI;
                end
                lzwd_pkg::PH_REF_HI: begin
                    o_push     = 1'b1;
                    o_cmd.kind = lzwd_pkg::CMD_REF;
                    o_cmd.lo   = r_ref_lo;
                    o_cmd.hi   = i_byte;
                    n_flag     = v_shift;
                    n_phase    = f_next(v_shift);
                end
                default: begin
                    n_phase    = lzwd_pkg::PH_FLAG;
                end
            endcase
        end
    end

endmodule

### rtl/core/lzwd_cmd_fifo.sv
module lzwd_cmd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lzwd_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output lzwd_pkg::t_q_status o_status,
    output logic                o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lzwd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           v_push, v_pop;

    assign o_full          = (r_cnt == FULL_CNT);
    assign o_status.empty  = (r_cnt == '0);
    assign o_status.head   = r_mem[r_rd];
    assign v_push          = i_push && !o_full;
    assign v_pop           = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (v_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (v_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({v_push, v_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/lzwd_back.sv
module lzwd_back #(
    parameter int unsigned WIN_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lzwd_pkg::t_q_status           i_q,
    output logic                          o_pop,
    input  logic [lzwd_pkg::LIMIT_W-1:0]  i_limit,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [7:0]                    o_m_tdata,
    output logic                          o_m_tlast
);

    localparam int unsigned AW = $clog2(WIN_BYTES);
    localparam int unsigned FW = AW + 1;
    localparam logic [AW-1:0] START_POS = AW'(WIN_BYTES - lzwd_pkg::START_BACK);
    localparam logic [FW-1:0] FILL_MAX  = FW'(WIN_BYTES);

    // copy sequencer
    logic [4:0]    r_remain, n_remain;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    // window bookkeeping: entries from START_POS up to the fill count are written
    logic [AW-1:0] r_wp, n_wp;
    logic [FW-1:0] r_fill, n_fill;
    logic [lzwd_pkg::LIMIT_W-1:0] r_count, n_count;
    // read stage
    logic          r_s1_valid, n_s1_valid;
    logic          r_s1_byp, n_s1_byp;
    logic          r_s1_zero, n_s1_zero;
    logic          r_s1_last, n_s1_last;
    logic [7:0]    r_s1_data, n_s1_data;
    // output register
    logic          r_o_valid, n_o_valid;
    logic          r_o_last, n_o_last;
    logic [7:0]    r_o_data, n_o_data;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    ram_q;
    logic [7:0]    s1_q;
    logic          s1_adv;

    assign s1_q   = r_s1_byp ? r_s1_data : (r_s1_zero ? 8'h00 : ram_q);
    assign s1_adv = r_s1_valid && (!r_o_valid || i_m_tready);

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WIN_BYTES)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_wp),
        .i_wdata (s1_q),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain   <= '0;
            r_wp       <= START_POS;
            r_fill     <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_remain   <= n_remain;
            r_wp       <= n_wp;
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr  <= n_rd_ptr;
        r_s1_byp  <= n_s1_byp;
        r_s1_zero <= n_s1_zero;
        r_s1_last <= n_s1_last;
        r_s1_data <= n_s1_data;
        r_o_last  <= n_o_last;
        r_o_data  <= n_o_data;
    end

    always_comb begin
        logic          v_slot;
        logic          v_emit;
        logic          v_load_rd;
        logic [AW-1:0] v_off;
        logic [AW-1:0] v_pos;
        logic [4:0]    v_len;
        logic [lzwd_pkg::LIMIT_W-1:0] v_cnt_inc;

        v_slot    = !r_s1_valid || s1_adv;
        v_emit    = (r_count < i_limit);
        v_cnt_inc = r_count + 1'b1;
        v_pos     = AW'({i_q.head.hi[7:4], i_q.head.lo});
        v_len     = {1'b0, i_q.head.hi[3:0]} + 5'(lzwd_pkg::MIN_COPY);
        v_load_rd = 1'b0;

        n_remain   = r_remain;
        n_rd_ptr   = r_rd_ptr;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_count    = r_count;
        n_s1_valid = r_s1_valid && !s1_adv;
        n_s1_byp   = r_s1_byp;
        n_s1_zero  = r_s1_zero;
        n_s1_last  = r_s1_last;
        n_s1_data  = r_s1_data;
        n_o_valid  = r_o_valid && !i_m_tready;
        n_o_last   = r_o_last;
        n_o_data   = r_o_data;
        rd_en      = 1'b0;
        rd_addr    = r_rd_ptr;
        o_pop      = 1'b0;

        // retire the read stage: window write, then emit until the limit is reached
        if (s1_adv) begin
            n_wp   = r_wp + 1'b1;
            n_fill = (r_fill == FILL_MAX) ? r_fill : r_fill + 1'b1;
            if (v_emit) begin
                n_count   = v_cnt_inc;
                n_o_valid = 1'b1;
                n_o_data  = s1_q;
                n_o_last  = r_s1_last || (v_cnt_inc == i_limit);
            end
        end

        if (r_remain != '0) begin
            if (v_slot) begin
                v_load_rd = 1'b1;
                rd_addr   = r_rd_ptr;
                n_rd_ptr  = r_rd_ptr + 1'b1;
                n_remain  = r_remain - 1'b1;
                n_s1_last = (r_remain == 5'd1);
            end
        end else if (!i_q.empty) begin
            case (i_q.head.kind)
                lzwd_pkg::CMD_CLEAR: begin
                    // wait until the last byte of the old stream is in the window
                    if (!r_s1_valid) begin
                        o_pop   = 1'b1;
                        n_wp    = START_POS;
                        n_fill  = '0;
                        n_count = '0;
                    end
                end
                lzwd_pkg::CMD_LIT: begin
                    if (v_slot) begin
                        o_pop      = 1'b1;
                        n_s1_valid = 1'b1;
                        n_s1_byp   = 1'b1;
                        n_s1_zero  = 1'b0;
                        n_s1_data  = i_q.head.lo;
                        n_s1_last  = 1'b1;
                    end
                end
                lzwd_pkg::CMD_REF: begin
                    if (v_slot) begin
                        o_pop     = 1'b1;
                        v_load_rd = 1'b1;
                        rd_addr   = v_pos;
                        n_rd_ptr  = v_pos + 1'b1;
                        n_remain  = v_len - 1'b1;
                        n_s1_last = 1'b0;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end

        if (v_load_rd) begin
            rd_en      = 1'b1;
            v_off      = rd_addr - START_POS;
            n_s1_valid = 1'b1;
            // forward the byte being written this cycle to the same address
            n_s1_byp   = s1_adv && (rd_addr == r_wp);
            n_s1_data  = s1_q;
            n_s1_zero  = !({1'b0, v_off} < r_fill);
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule

### rtl/core/lzwd_checker.sv
module lzwd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  o_m_tdata,
    input  logic        o_m_tlast,
    input  logic        pready
);

    // no output straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    // a stalled output transfer keeps its valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    // a stalled output transfer keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

endmodule

bind lzss_window_decompressor_top lzwd_checker u_lzwd_checker (.*);
